// ===== rtl/core/ds_pkg.sv =====
// shared types and constants for the descending sorter
// no dependencies; used by the interfaces, the cell and the top level
`timescale 1ns / 1ps
`default_nettype none

package ds_pkg;

   localparam int DATA_W            = 32;
   localparam int MAX_ITEMS_DEFAULT = 16;

   typedef logic signed [DATA_W-1:0] data_type;

   typedef enum logic [0:0] {
      ST_COLLECT,
      ST_DRAIN
   } state_type;

   // controls broadcast along the cell chain
   typedef struct packed {
      logic insert;
      logic drain;
   } cell_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/ds_if.sv =====
// valid/ready channel interfaces for request and response
// depends on ds_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ds_req_if;
   import ds_pkg::*;

   logic     valid;
   logic     ready;
   data_type value;
   logic     is_last;

   modport source (output valid, output value, output is_last, input ready);
   modport sink   (input valid, input value, input is_last, output ready);
endinterface

interface ds_rsp_if;
   import ds_pkg::*;

   logic     valid;
   logic     ready;
   data_type sorted_value;
   logic     last_out;
   logic     overflow;

   modport source (output valid, output sorted_value, output last_out, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_value, input last_out, input overflow,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ds_cell.sv =====
// one cell of the sorting chain: holds one value, inserts or shifts towards the head
// depends on ds_pkg
`timescale 1ns / 1ps
`default_nettype none

module ds_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 5
) (
   input  wire                     clock,
   input  ds_pkg::cell_ctrl_type   ctrl,
   input  wire [CNT_W-1:0]         count,
   input  ds_pkg::data_type        new_value,
   input  wire                     prev_gt,
   input  ds_pkg::data_type        prev_value,
   input  ds_pkg::data_type        next_value,
   output logic                    gt,
   output ds_pkg::data_type        value_ff
);
   import ds_pkg::*;

   data_type value_in;
   logic     empty;

   // an empty slot loses to any value; equal values stay ahead of the newcomer
   assign empty = (CNT_W'(INDEX) >= count);
   assign gt    = empty || (value_ff < new_value);

   always_comb begin
      value_in = value_ff;
      if (ctrl.drain) begin
         value_in = next_value;
      end else if (ctrl.insert && gt) begin
         value_in = prev_gt ? prev_value : new_value;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

// ===== rtl/core/descending_sorter.sv =====
// Descending sorter. Values arrive one per request and are inserted into a chain of
// MAX_ITEMS cells that stays sorted largest first, so a new request can be taken every
// clock while collecting. A request with is_last closes the set: the chain then shifts
// out from its head, one response per cycle while the sink is ready, the final one
// marked by last_out and all of them carrying overflow if any value of the set was
// dropped for lack of room. Requests are held off during this drain. Equal values come
// out in arrival order.
// depends on ds_pkg, ds_if and ds_cell
`timescale 1ns / 1ps
`default_nettype none

module descending_sorter #(
   parameter int MAX_ITEMS = ds_pkg::MAX_ITEMS_DEFAULT
) (
   input  wire       clock,
   input  wire       reset,
   ds_req_if.sink    req,
   ds_rsp_if.source  rsp
);
   import ds_pkg::*;

   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   cell_ctrl_type    ctrl;
   logic             req_fire, rsp_fire, full, final_out;

   data_type         cell_value [MAX_ITEMS];
   logic             cell_gt    [MAX_ITEMS];

   assign full      = (count_ff == CNT_W'(MAX_ITEMS));
   assign final_out = (count_ff == CNT_W'(1));
   assign req_fire  = req.valid && req.ready;
   assign rsp_fire  = rsp.valid && rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_COLLECT: begin
            if (req_fire && req.is_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (rsp_fire && final_out) state_in = ST_COLLECT;
         end
         default: state_in = ST_COLLECT;
      endcase
   end

   // outputs
   always_comb begin
      req.ready   = 1'b0;
      rsp.valid   = 1'b0;
      ctrl.insert = 1'b0;
      ctrl.drain  = 1'b0;
      unique case (state_ff)
         ST_COLLECT: begin
            req.ready   = 1'b1;
            ctrl.insert = req.valid && !full;
         end
         ST_DRAIN: begin
            rsp.valid  = 1'b1;
            ctrl.drain = rsp.ready;
         end
         default: begin
            req.ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      if (ctrl.insert) count_in = count_ff + CNT_W'(1);
      if (ctrl.drain)  count_in = count_ff - CNT_W'(1);
      if (req_fire && full) ovf_in = 1'b1;
      if (rsp_fire && final_out) ovf_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_COLLECT;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
      end
   end

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      data_type prev_value, next_value;
      logic     prev_gt;

      if (i == 0) begin : g_head
         assign prev_gt    = 1'b0;
         assign prev_value = req.value;
      end else begin : g_body
         assign prev_gt    = cell_gt[i-1];
         assign prev_value = cell_value[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign next_value = '0;
      end else begin : g_link
         assign next_value = cell_value[i+1];
      end

      ds_cell #(
         .INDEX (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .new_value  (req.value),
         .prev_gt    (prev_gt),
         .prev_value (prev_value),
         .next_value (next_value),
         .gt         (cell_gt[i]),
         .value_ff   (cell_value[i])
      );
   end

   assign rsp.sorted_value = cell_value[0];
   assign rsp.last_out     = final_out;
   assign rsp.overflow     = ovf_ff;

endmodule

`default_nettype wire
